@@ src/priority_insertion_sorter_unit_assert.svh @@
// Assertion macros used by the sorter datapath.
`ifndef PRIORITY_INSERTION_SORTER_UNIT_ASSERT_SVH
`define PRIORITY_INSERTION_SORTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PIS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define PIS_ASSERT(lbl, prop, msg)
`define PIS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ src/pis_pkg.sv @@
`default_nettype none

package pis_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [15:0] rank;
    logic [15:0]        amount;
    logic [7:0]         tag;
    logic               final_record;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_rank;
    logic [15:0]        out_amount;
    logic [7:0]         out_tag;
    logic               run_end;
    logic               dropped;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] rank;
    logic [15:0]        amount;
    logic [7:0]         tag;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic drop;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic one_left;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

`default_nettype wire

@@ src/pis_if.sv @@
`default_nettype none

interface pis_in_if;
  logic              valid;
  logic              ready;
  pis_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pis_out_if;
  logic               valid;
  logic               ready;
  pis_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/priority_insertion_sorter_unit.sv @@
// Stable descending priority sorter.
// Input channel in_i carries one record per word: rank, amount, tag and
// final_record. Each accepted word is inserted into a sorted register chain
// after all stored records of equal or higher rank, so one word per cycle
// is taken while the set is being collected.
// The word with final_record set starts the output run. From the next cycle
// on, out_o presents the stored records highest rank first, one word per
// cycle while out_ready is high; run_end marks the last word and dropped is
// set on every word of the run if any record of the set found the chain full.
// in_i is not ready during the run.
// A stall on out_o simply holds the current word; nothing is lost.
// Records beyond 32 are dropped. Reset empties the chain and clears the
// overflow flag; the record storage itself is not reset.
`default_nettype none

module priority_insertion_sorter_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pis_in_if.sink    in_i,
  pis_out_if.source out_o
);

  pis_pkg::cmd_t    cmd;
  pis_pkg::status_t status;

  pis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_final_i  (in_i.data.final_record),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pis_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_i.data),
    .status_o   (status),
    .out_word_o (out_o.data)
  );

endmodule

`default_nettype wire

@@ src/pis_ctrl.sv @@
`default_nettype none

module pis_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_final_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire pis_pkg::status_t status_i,
  output pis_pkg::cmd_t         cmd_o
);

  pis_pkg::state_e state_q, state_d;
  logic in_acc, out_acc;

  assign in_ready_o  = (state_q == pis_pkg::ST_IDLE);
  assign out_valid_o = (state_q == pis_pkg::ST_DRAIN);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.insert = in_acc && !status_i.full;
    cmd_o.drop   = in_acc && status_i.full;
    cmd_o.shift  = out_acc;
    unique case (state_q)
      pis_pkg::ST_IDLE: begin
        if (in_acc && in_final_i) begin
          state_d = pis_pkg::ST_DRAIN;
        end
      end
      pis_pkg::ST_DRAIN: begin
        if (out_acc && status_i.one_left) begin
          state_d = pis_pkg::ST_IDLE;
        end
      end
      default: state_d = pis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/pis_datapath.sv @@
`default_nettype none

`include "priority_insertion_sorter_unit_assert.svh"

module pis_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pis_pkg::cmd_t     cmd_i,
  input  wire pis_pkg::in_word_t in_word_i,
  output pis_pkg::status_t       status_o,
  output pis_pkg::out_word_t     out_word_o
);

  pis_pkg::rec_t cell_q [pis_pkg::DEPTH];
  pis_pkg::rec_t new_rec;
  logic [pis_pkg::DEPTH-1:0] ge;
  logic [pis_pkg::CNT_W-1:0] fill_q;
  logic overflow_q;

  assign new_rec.rank   = in_word_i.rank;
  assign new_rec.amount = in_word_i.amount;
  assign new_rec.tag    = in_word_i.tag;

  // On an insert, a cell keeps its record when it holds a stored one of greater or equal rank.
  // Because the chain is sorted, those cells form a prefix of the chain.
  for (genvar i = 0; i < int'(pis_pkg::DEPTH); i++) begin : g_cell
    logic take_new;
    pis_pkg::rec_t from_above;
    pis_pkg::rec_t from_below;

    assign ge[i] = (pis_pkg::CNT_W'(i) < fill_q) && (cell_q[i].rank >= in_word_i.rank);

    if (i == 0) begin : g_head
      assign take_new   = 1'b1;
      assign from_above = new_rec;
    end else begin : g_body
      assign take_new   = ge[i-1];
      assign from_above = cell_q[i-1];
    end

    if (i == int'(pis_pkg::DEPTH) - 1) begin : g_tail
      assign from_below = cell_q[i];
    end else begin : g_inner
      assign from_below = cell_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !ge[i]) begin
        if (take_new) begin
          cell_q[i] <= new_rec;
        end else begin
          cell_q[i] <= from_above;
        end
      end else if (cmd_i.shift) begin
        cell_q[i] <= from_below;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      overflow_q <= 1'b0;
    end else begin
      if (cmd_i.insert) begin
        fill_q <= fill_q + pis_pkg::CNT_W'(1);
      end else if (cmd_i.shift) begin
        fill_q <= fill_q - pis_pkg::CNT_W'(1);
      end
      if (cmd_i.drop) begin
        overflow_q <= 1'b1;
      end else if (cmd_i.shift && status_o.one_left) begin
        overflow_q <= 1'b0;
      end
    end
  end

  assign status_o.full     = (fill_q == pis_pkg::CNT_W'(pis_pkg::DEPTH));
  assign status_o.one_left = (fill_q == pis_pkg::CNT_W'(1));

  assign out_word_o.out_rank   = cell_q[0].rank;
  assign out_word_o.out_amount = cell_q[0].amount;
  assign out_word_o.out_tag    = cell_q[0].tag;
  assign out_word_o.run_end    = status_o.one_left;
  assign out_word_o.dropped    = overflow_q;

  `PIS_ASSERT(a_fill_bound, fill_q <= pis_pkg::CNT_W'(pis_pkg::DEPTH), "fill count above depth")
  `PIS_ASSERT(a_no_insert_full, cmd_i.insert |-> !status_o.full, "insert into a full store")
  `PIS_ASSERT(a_head_sorted, (fill_q >= pis_pkg::CNT_W'(2)) |-> (cell_q[0].rank >= cell_q[1].rank),
              "store head out of order")
  `PIS_ASSERT_NEXT(a_run_clears, cmd_i.shift && status_o.one_left,
                   (fill_q == '0) && !overflow_q, "store not empty after run")

endmodule

`default_nettype wire
